### rtl/brp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer with peek: shared package
// Action and status codes, field widths and the result descriptor.
// ----------------------------------------------------------------------------
package brp_pkg;

    localparam int DEPTH_DEFAULT   = 4096;
    localparam int RING_SIZE_RESET = 4096;

    localparam int ACTION_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int OFFSET_W    = 12;
    localparam int AMOUNT_W    = 13;
    localparam int MARK_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_OUT_W  = 13;
    localparam int RING_SIZE_W = 13;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = STATUS_W;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SKIP  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MARK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [MARK_W-1:0]     song_left;
        logic [FILL_OUT_W-1:0] fill_level;
        logic                  byte_valid;
    } res_info_t;

endpackage

### rtl/byte_ring_buffer_with_peek_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer with peek
// A circular byte store with write, pop, peek, skip and a countdown mark.
//
// Each transfer on the s_ channel carries one action and produces exactly
// one result transfer on the m_ channel, in order. A result passes the result
// stage, which waits for the storage read, then the output register. One action
// is accepted per cycle while s_tready is high; the rate is set by the single
// storage RAM, serving one write or one read per cycle, with a registered read.
// The s_ side keeps accepting while one finished result waits in the output
// register; when the receiver holds m_tready low, at most two results are
// held inside and s_tready drops until the output register drains.
// The cfg_ channel writes the ring size; it clears the read index, fill
// count and countdown, and is meant to be used only while the block is idle.
// Reset sets the ring size to 4096 (limited to DEPTH) and empties the
// buffer; no clearing pass is needed, since only written bytes are read.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek_unit #(
    parameter int DEPTH = brp_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: data_byte[7:0], offset[19:8], amount[32:20], song_mark[64:33]
    input  logic [brp_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: action[2:0]
    input  logic [brp_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: read_byte[7:0], song_left[39:8], fill_level[52:40]
    output logic [brp_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: status[1:0]
    output logic [brp_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [brp_pkg::RING_SIZE_W-1:0]   cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    localparam int AW = $clog2(DEPTH);

    logic                               issue;
    logic                               cfg_we;
    brp_pkg::res_info_t                 info;
    logic                               ram_we, ram_re;
    logic [AW-1:0]                      ram_waddr, ram_raddr;
    logic [brp_pkg::BYTE_W-1:0]         ram_wdata, ram_rdata;
    logic [brp_pkg::STATUS_W-1:0]       out_status;
    logic [brp_pkg::BYTE_W-1:0]         out_byte;
    logic [brp_pkg::MARK_W-1:0]         out_song;
    logic [brp_pkg::FILL_OUT_W-1:0]     out_fill;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign issue     = s_tvalid && s_tready;

    brp_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .action    (s_tuser[2:0]),
        .data_byte (s_tdata[7:0]),
        .offset    (s_tdata[19:8]),
        .amount    (s_tdata[32:20]),
        .song_mark (s_tdata[64:33]),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .info      (info)
    );

    brp_ram #(
        .WIDTH(brp_pkg::BYTE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brp_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .issue        (issue),
        .info         (info),
        .ram_rdata    (ram_rdata),
        .in_ready     (s_tready),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_status     (out_status),
        .m_read_byte  (out_byte),
        .m_song_left  (out_song),
        .m_fill_level (out_fill)
    );

    assign m_tuser = out_status;
    assign m_tdata = {3'b000, out_fill, out_song, out_byte};

endmodule

### rtl/brp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module brp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/brp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer control
// Holds read index, fill count, countdown and effective size; decodes each
// action into at most one storage access and a result descriptor.
// ----------------------------------------------------------------------------
module brp_ctrl #(
    parameter int DEPTH = brp_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                issue,
    input  logic [brp_pkg::ACTION_W-1:0]        action,
    input  logic [brp_pkg::BYTE_W-1:0]          data_byte,
    input  logic [brp_pkg::OFFSET_W-1:0]        offset,
    input  logic [brp_pkg::AMOUNT_W-1:0]        amount,
    input  logic [brp_pkg::MARK_W-1:0]          song_mark,
    input  logic                                cfg_we,
    input  logic [brp_pkg::RING_SIZE_W-1:0]     cfg_data,
    output logic                                ram_we,
    output logic [$clog2(DEPTH)-1:0]            ram_waddr,
    output logic [brp_pkg::BYTE_W-1:0]          ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(DEPTH)-1:0]            ram_raddr,
    output brp_pkg::res_info_t                  info
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int MW = (FW > brp_pkg::AMOUNT_W) ? FW : brp_pkg::AMOUNT_W;
    localparam int CW = MW + 1;
    localparam int SIZE_RST = (brp_pkg::RING_SIZE_RESET > DEPTH) ? DEPTH
                                                                 : brp_pkg::RING_SIZE_RESET;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [AW-1:0]                rd_idx_reg, rd_idx_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [brp_pkg::MARK_W-1:0]   song_reg, song_next;
    logic [FW-1:0]                size_reg, size_next;

    logic [CW-1:0] fill_c, size_c, idx_c, len_c, sum_c, wrap_c, ring_c;

    always_comb begin
        fill_c = CW'(fill_reg);
        size_c = CW'(size_reg);
        idx_c  = CW'(rd_idx_reg);
        ring_c = CW'(cfg_data);

        case (action)
            brp_pkg::ACT_WRITE: len_c = fill_c;
            brp_pkg::ACT_POP:   len_c = CW'(1);
            brp_pkg::ACT_PEEK:  len_c = CW'(offset);
            brp_pkg::ACT_SKIP:  len_c = CW'(amount);
            default:            len_c = '0;
        endcase
        sum_c  = idx_c + len_c;
        wrap_c = (sum_c >= size_c) ? (sum_c - size_c) : sum_c;

        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        song_next   = song_reg;
        size_next   = size_reg;

        ram_we    = 1'b0;
        ram_waddr = AW'(wrap_c);
        ram_wdata = data_byte;
        ram_re    = 1'b0;
        ram_raddr = (action == brp_pkg::ACT_POP) ? rd_idx_reg : AW'(wrap_c);

        info.status     = brp_pkg::ST_OK;
        info.song_left  = '0;
        info.byte_valid = 1'b0;

        if (issue) begin
            case (action)
                brp_pkg::ACT_WRITE: begin
                    if (fill_c >= size_c) begin
                        info.status = brp_pkg::ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
                brp_pkg::ACT_POP: begin
                    if (fill_reg == '0) begin
                        info.status = brp_pkg::ST_EMPTY;
                    end else begin
                        ram_re          = 1'b1;
                        info.byte_valid = 1'b1;
                        info.song_left  = song_reg;
                        rd_idx_next     = AW'(wrap_c);
                        fill_next       = fill_reg - FW'(1);
                        if (song_reg != '0) begin
                            song_next = song_reg - 32'd1;
                        end
                    end
                end
                brp_pkg::ACT_PEEK: begin
                    if ((CW'(amount) > fill_c) || (CW'(offset) >= fill_c)) begin
                        info.status = brp_pkg::ST_EMPTY;
                    end else begin
                        ram_re          = 1'b1;
                        info.byte_valid = 1'b1;
                    end
                end
                brp_pkg::ACT_SKIP: begin
                    if (CW'(amount) > fill_c) begin
                        info.status = brp_pkg::ST_EMPTY;
                    end else begin
                        rd_idx_next = AW'(wrap_c);
                        fill_next   = FW'(fill_c - CW'(amount));
                    end
                end
                brp_pkg::ACT_MARK: begin
                    song_next = song_mark;
                end
                default: begin
                end
            endcase
        end

        info.fill_level = brp_pkg::FILL_OUT_W'(CW'(fill_next));

        if (cfg_we) begin
            rd_idx_next = '0;
            fill_next   = '0;
            song_next   = '0;
            if (ring_c == '0) begin
                size_next = FW'(1);
            end else if (ring_c > DEPTH_C) begin
                size_next = FW'(DEPTH_C);
            end else begin
                size_next = FW'(ring_c);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            fill_reg   <= '0;
            song_reg   <= '0;
            size_reg   <= FW'(SIZE_RST);
        end else begin
            rd_idx_reg <= rd_idx_next;
            fill_reg   <= fill_next;
            song_reg   <= song_next;
            size_reg   <= size_next;
        end
    end

endmodule

### rtl/brp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result stage and output register
// Holds each result in a stage register during the storage read, then moves
// it into the output register, which is decoupled from the receiver.
// ----------------------------------------------------------------------------
module brp_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              issue,
    input  brp_pkg::res_info_t                info,
    input  logic [brp_pkg::BYTE_W-1:0]        ram_rdata,
    output logic                              in_ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [brp_pkg::STATUS_W-1:0]      m_status,
    output logic [brp_pkg::BYTE_W-1:0]        m_read_byte,
    output logic [brp_pkg::MARK_W-1:0]        m_song_left,
    output logic [brp_pkg::FILL_OUT_W-1:0]    m_fill_level
);

    logic                             p1_valid_reg, p1_valid_next;
    brp_pkg::res_info_t               p1_info_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [brp_pkg::STATUS_W-1:0]     status_reg;
    logic [brp_pkg::BYTE_W-1:0]       byte_reg;
    logic [brp_pkg::MARK_W-1:0]       song_reg;
    logic [brp_pkg::FILL_OUT_W-1:0]   fill_reg;
    logic                             advance;

    assign advance  = p1_valid_reg && (!out_valid_reg || m_ready);
    assign in_ready = !p1_valid_reg || advance;

    always_comb begin
        p1_valid_next  = p1_valid_reg;
        out_valid_next = out_valid_reg;
        if (issue) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_info_reg <= info;
        end
        if (advance) begin
            status_reg <= p1_info_reg.status;
            byte_reg   <= p1_info_reg.byte_valid ? ram_rdata : '0;
            song_reg   <= p1_info_reg.song_left;
            fill_reg   <= p1_info_reg.fill_level;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_read_byte  = byte_reg;
    assign m_song_left  = song_reg;
    assign m_fill_level = fill_reg;

endmodule
